[rtl/core/sorted_list_engine_assert.svh]
// Assertion macros shared by the sorted list engine RTL.
`ifndef SORTED_LIST_ENGINE_ASSERT_SVH
`define SORTED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/sle_pkg.sv]
// Shared types and constants for the sorted list engine.
package sle_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// fixed widths of the result fields
	localparam int IDX_OUT_W = 4;
	localparam int CNT_OUT_W = 5;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_POP    = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_SEARCH = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                     kind;
		logic signed [DATA_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic                      ok;
		logic signed [DATA_W-1:0]  popped_value;
		logic [IDX_OUT_W-1:0]      found_index;
		logic [CNT_OUT_W-1:0]      removed_count;
		logic [CNT_OUT_W-1:0]      fill_level;
	} rsp_t;

endpackage

[rtl/core/sle_store.sv]
// Entry memory: one write port, one read port, registered read data.
module sle_store (
	input  logic                              clk,
	input  logic                              we,
	input  logic [sle_pkg::ADDR_W-1:0]        waddr,
	input  logic signed [sle_pkg::DATA_W-1:0] wdata,
	input  logic                              re,
	input  logic [sle_pkg::ADDR_W-1:0]        raddr,
	output logic signed [sle_pkg::DATA_W-1:0] rdata
);
	import sle_pkg::*;

	logic signed [DATA_W-1:0] mem_q [CAPACITY];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, read data registered while re is high
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/sorted_list_engine.sv]
// Sorted list engine: ascending list of signed values held in one entry memory.
// Each item runs from an accepted start to one strobe; a full-list insert or an empty-list pop
// is answered straight from idle, without touching the entry memory.
// One item at a time, busy high meanwhile; the single memory read port moves one
// entry per cycle. The result is shown for one cycle.
// Reset clears the fill count and control; entry memory is left as is, no sweep.
module sorted_list_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sle_pkg::req_t  req,
	output logic           strobe,
	output sle_pkg::rsp_t  rsp
);
	import sle_pkg::*;

	`include "sorted_list_engine_assert.svh"

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_INS    = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_POP_RD = 6'b001000,
		ST_POP_WT = 6'b010000,
		ST_COPY   = 6'b100000
	} state_t;

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         cnt_q, cnt_d;
	logic                     pend_q, pend_d;
	logic                     strobe_q, strobe_d;
	logic [CNT_W-1:0]         ptr_q, ptr_d;
	logic [CNT_W-1:0]         idx_s1, idx_d;
	logic [CNT_W-1:0]         k_q, k_d;
	logic signed [DATA_W-1:0] val_q, val_d;
	kind_t                    kind_q, kind_d;
	logic signed [DATA_W-1:0] popped_q, popped_d;
	rsp_t                     rsp_q, rsp_d;

	logic                     re_c, we_c;
	logic [ADDR_W-1:0]        raddr_c, waddr_c;
	logic signed [DATA_W-1:0] wdata_c, rdata;

	logic [CNT_W-1:0]         ptr_m1_c, ptr_m2_c, copy_dst_c, cnt_p1_c;
	logic                     full_c, stop_c;

	sle_store u_store (
		.clk   (clk),
		.we    (we_c),
		.waddr (waddr_c),
		.wdata (wdata_c),
		.re    (re_c),
		.raddr (raddr_c),
		.rdata (rdata)
	);

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign rsp    = rsp_q;

	assign ptr_m1_c   = ptr_q - CNT_W'(1);
	assign ptr_m2_c   = ptr_q - CNT_W'(2);
	assign copy_dst_c = idx_s1 - k_q;
	assign cnt_p1_c   = cnt_q + CNT_W'(1);
	assign full_c     = (cnt_q == CNT_W'(CAPACITY));

	// scan stops at the first entry >= threshold, or at the first match
	assign stop_c = pend_q && ((kind_q == KIND_REMOVE) ? !(rdata < val_q) : (rdata == val_q));

	// sequencer: reads run one entry per cycle, each write follows in the cycle after its read.
	// Shifts move away from the read pointer, so no write hits a later read.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		pend_d   = 1'b0;
		strobe_d = 1'b0;
		ptr_d    = ptr_q;
		idx_d    = idx_s1;
		k_d      = k_q;
		val_d    = val_q;
		kind_d   = kind_q;
		popped_d = popped_q;
		rsp_d    = rsp_q;
		re_c     = 1'b0;
		raddr_c  = '0;
		we_c     = 1'b0;
		waddr_c  = '0;
		wdata_c  = val_q;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					val_d  = req.value;
					kind_d = req.kind;
					ptr_d  = '0;
					rsp_d  = '0;
					case (req.kind)
						KIND_INSERT: begin
							if (full_c) begin
								strobe_d         = 1'b1;
								rsp_d.fill_level = CNT_OUT_W'(cnt_q);
							end else begin
								ptr_d   = cnt_q;
								state_d = ST_INS;
							end
						end
						KIND_POP: begin
							if (cnt_q == '0) begin
								strobe_d         = 1'b1;
								rsp_d.fill_level = CNT_OUT_W'(cnt_q);
							end else begin
								state_d = ST_POP_RD;
							end
						end
						KIND_REMOVE, KIND_SEARCH: begin
							state_d = ST_SCAN;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end

			// walk down from the tail, moving entries >= value up by one
			ST_INS: begin
				if (pend_q) begin
					we_c    = 1'b1;
					waddr_c = ptr_q[ADDR_W-1:0];
					if (rdata >= val_q) begin
						wdata_c = rdata;
						ptr_d   = ptr_m1_c;
						if (ptr_q > CNT_W'(1)) begin
							re_c    = 1'b1;
							raddr_c = ptr_m2_c[ADDR_W-1:0];
							pend_d  = 1'b1;
						end
					end else begin
						wdata_c          = val_q;
						cnt_d            = cnt_p1_c;
						strobe_d         = 1'b1;
						rsp_d.ok         = 1'b1;
						rsp_d.fill_level = CNT_OUT_W'(cnt_p1_c);
						state_d          = ST_IDLE;
					end
				end else if (ptr_q == '0) begin
					we_c             = 1'b1;
					waddr_c          = '0;
					wdata_c          = val_q;
					cnt_d            = cnt_p1_c;
					strobe_d         = 1'b1;
					rsp_d.ok         = 1'b1;
					rsp_d.fill_level = CNT_OUT_W'(cnt_p1_c);
					state_d          = ST_IDLE;
				end else begin
					re_c    = 1'b1;
					raddr_c = ptr_m1_c[ADDR_W-1:0];
					pend_d  = 1'b1;
				end
			end

			// forward scan for remove-below and search
			ST_SCAN: begin
				if (stop_c) begin
					if (kind_q == KIND_REMOVE) begin
						if (idx_s1 == '0) begin
							strobe_d         = 1'b1;
							rsp_d.ok         = 1'b1;
							rsp_d.fill_level = CNT_OUT_W'(cnt_q);
							state_d          = ST_IDLE;
						end else begin
							k_d     = idx_s1;
							ptr_d   = idx_s1;
							state_d = ST_COPY;
						end
					end else begin
						strobe_d          = 1'b1;
						rsp_d.ok          = 1'b1;
						rsp_d.found_index = IDX_OUT_W'(idx_s1);
						rsp_d.fill_level  = CNT_OUT_W'(cnt_q);
						state_d           = ST_IDLE;
					end
				end else if (ptr_q < cnt_q) begin
					re_c    = 1'b1;
					raddr_c = ptr_q[ADDR_W-1:0];
					idx_d   = ptr_q;
					ptr_d   = ptr_q + CNT_W'(1);
					pend_d  = 1'b1;
				end else if (!pend_q) begin
					// every entry seen without a stop
					strobe_d = 1'b1;
					state_d  = ST_IDLE;
					if (kind_q == KIND_REMOVE) begin
						cnt_d               = '0;
						rsp_d.ok            = 1'b1;
						rsp_d.removed_count = CNT_OUT_W'(cnt_q);
						rsp_d.fill_level    = '0;
					end else begin
						rsp_d.fill_level = CNT_OUT_W'(cnt_q);
					end
				end
			end

			ST_POP_RD: begin
				re_c    = 1'b1;
				raddr_c = '0;
				pend_d  = 1'b1;
				state_d = ST_POP_WT;
			end

			ST_POP_WT: begin
				popped_d = rdata;
				k_d      = CNT_W'(1);
				ptr_d    = CNT_W'(1);
				state_d  = ST_COPY;
			end

			// move entries k..n-1 down to 0..n-k-1
			ST_COPY: begin
				if (pend_q) begin
					we_c    = 1'b1;
					waddr_c = copy_dst_c[ADDR_W-1:0];
					wdata_c = rdata;
				end
				if (ptr_q < cnt_q) begin
					re_c    = 1'b1;
					raddr_c = ptr_q[ADDR_W-1:0];
					idx_d   = ptr_q;
					ptr_d   = ptr_q + CNT_W'(1);
					pend_d  = 1'b1;
				end else if (!pend_q) begin
					cnt_d            = cnt_q - k_q;
					strobe_d         = 1'b1;
					rsp_d.ok         = 1'b1;
					rsp_d.fill_level = CNT_OUT_W'(cnt_q - k_q);
					if (kind_q == KIND_POP) begin
						rsp_d.popped_value = popped_q;
					end else begin
						rsp_d.removed_count = CNT_OUT_W'(k_q);
					end
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			pend_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			pend_q   <= pend_d;
			strobe_q <= strobe_d;
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		ptr_q    <= ptr_d;
		idx_s1   <= idx_d;
		k_q      <= k_d;
		val_q    <= val_d;
		kind_q   <= kind_d;
		popped_q <= popped_d;
		rsp_q    <= rsp_d;
	end

	// checks
	`SLE_ASSERT_NOW(a_strobe_idle, strobe_q, state_q == ST_IDLE, "result shown while busy")
	`SLE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY), "fill count past capacity")
	`SLE_ASSERT_NEXT(a_accept_acts, start && !busy, busy || strobe_q, "item accepted but dropped")
	`SLE_ASSERT_NOW(a_write_busy, we_c, state_q != ST_IDLE, "memory written while idle")
	`SLE_ASSERT_NOW(a_copy_order, we_c && re_c && (state_q == ST_COPY), waddr_c < raddr_c,
		"copy write overtakes read")

endmodule

[bench/sorted_list_engine_tb.sv]
// Testbench for sorted_list_engine: directed and random requests checked against a list model.
`timescale 1ns / 1ps

module sorted_list_engine_tb;
	import sle_pkg::*;

	localparam int VAL_MIN = 32'sh8000_0000;
	localparam int VAL_MAX = 32'sh7fff_ffff;
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

	// Model of the sorted list plus the queue of responses still owed by the engine
	class list_tracker;
		int held[CAPACITY];
		int count;
		rsp_t due_results[$];
		int errors;
		int checked;
		int kind_seen[4];
		int full_inserts;
		int empty_pops;
		int search_hits;
		int dropped_total;

		task report(string msg);
			errors++;
			$display("%0t ns: MISMATCH %s", $time, msg);
		endtask

		// Apply one accepted request to the model and queue its response
		function void note_request(req_t r);
			rsp_t want;
			int pos;
			int keep;
			int v;
			want = '0;
			v = r.value;
			kind_seen[r.kind]++;
			case (r.kind)
				KIND_INSERT: begin
					if (count < CAPACITY) begin
						pos = 0;
						while (pos < count && held[pos] < v)
							pos++;
						for (int j = count; j > pos; j--)
							held[j] = held[j - 1];
						held[pos] = v;
						count++;
						want.ok = 1'b1;
					end else begin
						full_inserts++;
					end
				end
				KIND_POP: begin
					if (count > 0) begin
						want.popped_value = held[0];
						for (int j = 0; j + 1 < count; j++)
							held[j] = held[j + 1];
						count--;
						want.ok = 1'b1;
					end else begin
						empty_pops++;
					end
				end
				KIND_REMOVE: begin
					// keep entries at or above the threshold, in order
					keep = 0;
					for (int j = 0; j < count; j++) begin
						if (held[j] >= v) begin
							held[keep] = held[j];
							keep++;
						end
					end
					want.removed_count = CNT_OUT_W'(count - keep);
					dropped_total += count - keep;
					count = keep;
					want.ok = 1'b1;
				end
				default: begin
					pos = 0;
					while (pos < count && held[pos] != v)
						pos++;
					if (pos < count) begin
						want.ok = 1'b1;
						want.found_index = IDX_OUT_W'(pos);
						search_hits++;
					end
				end
			endcase
			want.fill_level = CNT_OUT_W'(count);
			due_results.push_back(want);
		endfunction

		// Compare one response with the oldest one owed
		task check_result(rsp_t got);
			rsp_t want;
			if (due_results.size() == 0) begin
				report("response with no request outstanding");
				return;
			end
			want = due_results.pop_front();
			checked++;
			if (got.ok !== want.ok)
				report($sformatf("ok got %0b expected %0b", got.ok, want.ok));
			if (got.popped_value !== want.popped_value)
				report($sformatf("popped_value got %0d expected %0d",
					got.popped_value, want.popped_value));
			if (got.found_index !== want.found_index)
				report($sformatf("found_index got %0d expected %0d",
					got.found_index, want.found_index));
			if (got.removed_count !== want.removed_count)
				report($sformatf("removed_count got %0d expected %0d",
					got.removed_count, want.removed_count));
			if (got.fill_level !== want.fill_level)
				report($sformatf("fill_level got %0d expected %0d",
					got.fill_level, want.fill_level));
		endtask
	endclass

	logic  clk;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  busy;
	req_t  req = '0;
	logic  strobe;
	rsp_t  rsp;

	list_tracker tracker = new();

	sorted_list_engine uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.strobe (strobe),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Note accepted items and check responses on the same edge
	always @(posedge clk) begin
		if (arst_n && start && busy === 1'b0)
			tracker.note_request(req);
		if (arst_n && strobe === 1'b1)
			tracker.check_result(rsp);
	end

	// Present one item, optionally after an idle gap, and hold it until taken
	task automatic send_item(kind_t k, int v, int idle_pct);
		req_t r;
		int gap;
		gap = 0;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct)
			gap = $urandom_range(1, 40);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r.kind = k;
		r.value = v;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Stop sending until every owed response has come back; the first edge lets the
	// monitor note the item accepted on the previous one
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (tracker.due_results.size() != 0);
	endtask

	// Values: small range for duplicates and hits, full range, extremes, stored entries
	function automatic int pick_value();
		int pick;
		pick = $urandom_range(5);
		if (pick < 2)
			return int'($urandom_range(16)) - 8;
		if (pick == 2)
			return $urandom;
		if (pick == 3) begin
			case ($urandom_range(3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return 0;
				default: return -1;
			endcase
		end
		if (tracker.count > 0)
			return tracker.held[$urandom_range(tracker.count - 1)];
		return $urandom_range(4);
	endfunction

	// mode 0 fills the list, mode 1 drains it, mode 2 is balanced
	function automatic kind_t pick_kind(int mode);
		int roll;
		roll = $urandom_range(99);
		case (mode)
			0: begin
				if (roll < 60) return KIND_INSERT;
				if (roll < 70) return KIND_POP;
				if (roll < 75) return KIND_REMOVE;
				return KIND_SEARCH;
			end
			1: begin
				if (roll < 25) return KIND_INSERT;
				if (roll < 60) return KIND_POP;
				if (roll < 75) return KIND_REMOVE;
				return KIND_SEARCH;
			end
			default: begin
				if (roll < 35) return KIND_INSERT;
				if (roll < 55) return KIND_POP;
				if (roll < 65) return KIND_REMOVE;
				return KIND_SEARCH;
			end
		endcase
	endfunction

	task automatic run_phase(int items, int idle_pct);
		int mode;
		mode = 2;
		for (int n = 0; n < items; n++) begin
			if (n % 40 == 0)
				mode = $urandom_range(2);
			send_item(pick_kind(mode), pick_value(), idle_pct);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corner cases
		send_item(KIND_POP, 0, 0);
		send_item(KIND_SEARCH, 0, 0);
		send_item(KIND_REMOVE, VAL_MIN, 0);
		// extremes and a duplicate
		send_item(KIND_INSERT, VAL_MAX, 0);
		send_item(KIND_INSERT, VAL_MIN, 0);
		send_item(KIND_INSERT, 0, 0);
		send_item(KIND_INSERT, -1, 0);
		send_item(KIND_INSERT, 0, 0);
		send_item(KIND_SEARCH, 0, 0);
		send_item(KIND_SEARCH, 5, 0);
		send_item(KIND_POP, 0, 0);
		send_item(KIND_REMOVE, 0, 0);
		// fill to capacity, then insert into a full list
		while (tracker.count < CAPACITY) begin
			send_item(KIND_INSERT, $urandom_range(32'h7fff_fffe), 0);
			settle();
		end
		send_item(KIND_INSERT, 1, 0);
		send_item(KIND_SEARCH, VAL_MAX, 0);
		send_item(KIND_REMOVE, VAL_MAX, 0);
		send_item(KIND_REMOVE, VAL_MIN, 0);
		settle();

		run_phase(610, 26);
		settle();
		run_phase(610, 56);
		settle();
		run_phase(602, 0);
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d inserts (%0d into a full list), %0d pops (%0d on empty),",
			tracker.kind_seen[KIND_INSERT], tracker.full_inserts,
			tracker.kind_seen[KIND_POP], tracker.empty_pops);
		$display("%0d remove-below dropping %0d entries, %0d searches (%0d hits); %0d checked",
			tracker.kind_seen[KIND_REMOVE], tracker.dropped_total,
			tracker.kind_seen[KIND_SEARCH], tracker.search_hits, tracker.checked);
		if (tracker.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Timeout with %0d responses outstanding", tracker.due_results.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
